// ===== hdl/pca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the Q2.14 product function for the pairwise
// correlation attenuator. No dependencies.

package pca_pkg;

    // Fixed-point format
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int YEAR_BITS = 12;
    localparam int CODE_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic [YEAR_BITS-1:0]     t_year;
    typedef logic [CODE_W-1:0]        t_code;

    localparam t_q Q_ONE = t_q'(1 << FRAC_BITS);

    // Rounding offsets: ties away from zero
    localparam logic signed [SUM_W-1:0] RND_POS = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] RND_NEG = RND_POS - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(Q_ONE);
    localparam logic signed [SUM_W-1:0] SAT_LO  = -SAT_HI;

    // Pipeline depth: input stage, one stage per gap bit, year, stratum, source
    localparam int NUM_STAGES = YEAR_BITS + 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAC_LOC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAC_YEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAC_STRAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAC_SRC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAC_DET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AR_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOC_EN    = 3'd6;

    // Input tdata layout, last-declared field (correlation_in) in the lowest bits
    typedef struct packed {
        t_code details_second;
        t_code details_first;
        t_code source_second;
        t_code source_first;
        t_code stratum_second;
        t_code stratum_first;
        t_year year_second;
        t_year year_first;
        t_code loc_second;
        t_code loc_first;
        t_q    correlation_in;
    } t_in_data;

    localparam int IN_W  = $bits(t_in_data);
    localparam int OUT_W = DATA_W;

    // Mismatch flags of one pair
    typedef struct packed {
        logic loc_ne;
        logic year_ne;
        logic strat_ne;
        logic src_ne;
        logic det_ne;
    } t_flags;

    // Item state carried down the pipeline
    typedef struct packed {
        t_q     corr;
        t_year  gap;
        t_flags flags;
        logic   last;
    } t_item;

    // Product rounded to nearest (ties away from zero), saturated to +/-1.0
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [PROD_W-1:0] p;
        logic signed [SUM_W-1:0]  s;
        logic signed [SUM_W-1:0]  r;
        t_q                       y;
        p = a * b;
        s = SUM_W'(p) + (p[PROD_W-1] ? RND_NEG : RND_POS);
        r = s >>> FRAC_BITS;
        if (r > SAT_HI) begin
            y = Q_ONE;
        end else if (r < SAT_LO) begin
            y = -Q_ONE;
        end else begin
            y = r[DATA_W-1:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pairwise_correlation_attenuator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pairwise correlation attenuator, 16-stage pipeline; depends on pca_pkg.
// Throughput one item per cycle while i_m_axis_tready holds; the AR1 power chain
// (one square-and-multiply per gap bit) makes up most of the pipeline.
// Each stage advances whenever it is empty or its successor advances.
// Synchronous active-low reset clears valid bits and loads all factors with
// 1.0, AR1 mode off and location compare off.

module pairwise_correlation_attenuator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_wen,
    input  wire logic [pca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pca_pkg::DATA_W-1:0]    i_cfg_wdata,
    // input items
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata low to high: correlation_in, loc_first, loc_second, year_first,
    // year_second, stratum_first, stratum_second, source_first,
    // source_second, details_first, details_second
    input  wire logic [pca_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast,   // last_pair
    // result items
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: correlation_out
    output logic [pca_pkg::OUT_W-1:0]          o_m_axis_tdata,
    output logic                               o_m_axis_tlast    // last_out
);

    localparam int NST = pca_pkg::NUM_STAGES;
    localparam int YB  = pca_pkg::YEAR_BITS;

    // Configuration registers
    pca_pkg::t_q r_fac_loc;
    pca_pkg::t_q r_fac_year;
    pca_pkg::t_q r_fac_strat;
    pca_pkg::t_q r_fac_src;
    pca_pkg::t_q r_fac_det;
    logic        r_ar_mode;
    logic        r_loc_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fac_loc   <= pca_pkg::Q_ONE;
            r_fac_year  <= pca_pkg::Q_ONE;
            r_fac_strat <= pca_pkg::Q_ONE;
            r_fac_src   <= pca_pkg::Q_ONE;
            r_fac_det   <= pca_pkg::Q_ONE;
            r_ar_mode   <= 1'b0;
            r_loc_en    <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                pca_pkg::CFG_FAC_LOC:   r_fac_loc   <= i_cfg_wdata;
                pca_pkg::CFG_FAC_YEAR:  r_fac_year  <= i_cfg_wdata;
                pca_pkg::CFG_FAC_STRAT: r_fac_strat <= i_cfg_wdata;
                pca_pkg::CFG_FAC_SRC:   r_fac_src   <= i_cfg_wdata;
                pca_pkg::CFG_FAC_DET:   r_fac_det   <= i_cfg_wdata;
                pca_pkg::CFG_AR_MODE:   r_ar_mode   <= i_cfg_wdata[0];
                pca_pkg::CFG_LOC_EN:    r_loc_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic              r_vld  [0:NST-1];
    pca_pkg::t_item    r_item [0:NST-1];
    pca_pkg::t_q       r_pw   [0:YB];
    pca_pkg::t_q       r_base [0:YB-1];
    logic [NST:0]      w_adv;

    // Advance chain: a stage moves when empty or when its successor moves
    assign w_adv[NST] = i_m_axis_tready;
    for (genvar k = 0; k < NST; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    assign o_s_axis_tready = w_adv[0];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: unpack, compare codes, year gap
    pca_pkg::t_in_data w_in;
    pca_pkg::t_item    n_item0;

    assign w_in = pca_pkg::t_in_data'(i_s_axis_tdata);

    always_comb begin
        n_item0.corr           = w_in.correlation_in;
        n_item0.gap            = (w_in.year_first >= w_in.year_second)
                               ? (w_in.year_first - w_in.year_second)
                               : (w_in.year_second - w_in.year_first);
        n_item0.flags.loc_ne   = r_loc_en && (w_in.loc_first != w_in.loc_second);
        n_item0.flags.year_ne  = (w_in.year_first != w_in.year_second);
        n_item0.flags.strat_ne = (w_in.stratum_first != w_in.stratum_second);
        n_item0.flags.src_ne   = (w_in.source_first != w_in.source_second);
        n_item0.flags.det_ne   = (w_in.details_first != w_in.details_second);
        n_item0.last           = i_s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_item[0] <= n_item0;
            r_pw[0]   <= pca_pkg::Q_ONE;
            r_base[0] <= r_fac_year;
        end
    end

    // Stages 1..YB: one square-and-multiply step per gap bit;
    // stage 1 also applies the location factor
    for (genvar j = 0; j < YB; j++) begin : g_pow
        pca_pkg::t_q    n_pw;
        pca_pkg::t_item n_item;

        always_comb begin
            n_pw   = r_item[j].gap[j] ? pca_pkg::qmul(r_pw[j], r_base[j]) : r_pw[j];
            n_item = r_item[j];
            if (j == 0) begin
                if (r_item[j].flags.loc_ne) begin
                    n_item.corr = pca_pkg::qmul(r_item[j].corr, r_fac_loc);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[j+1]) begin
                r_item[j+1] <= n_item;
                r_pw[j+1]   <= n_pw;
            end
        end

        // the square of the top bit's base is never used
        if (j < YB - 1) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (w_adv[j+1]) begin
                    r_base[j+1] <= pca_pkg::qmul(r_base[j], r_base[j]);
                end
            end
        end
    end

    // Year stage: AR1 power or flat factor
    pca_pkg::t_q    w_year_fac;
    pca_pkg::t_item n_item_year;

    always_comb begin
        w_year_fac  = r_ar_mode ? r_pw[YB] : r_fac_year;
        n_item_year = r_item[YB];
        if (r_item[YB].flags.year_ne) begin
            n_item_year.corr = pca_pkg::qmul(r_item[YB].corr, w_year_fac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[YB+1]) begin
            r_item[YB+1] <= n_item_year;
        end
    end

    // Stratum stage
    pca_pkg::t_item n_item_strat;

    always_comb begin
        n_item_strat = r_item[YB+1];
        if (r_item[YB+1].flags.strat_ne) begin
            n_item_strat.corr = pca_pkg::qmul(r_item[YB+1].corr, r_fac_strat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[YB+2]) begin
            r_item[YB+2] <= n_item_strat;
        end
    end

    // Source stage, details only when sources match; feeds the output register
    pca_pkg::t_q    w_sd_fac;
    pca_pkg::t_item n_item_out;

    always_comb begin
        w_sd_fac   = r_item[YB+2].flags.src_ne ? r_fac_src : r_fac_det;
        n_item_out = r_item[YB+2];
        if (r_item[YB+2].flags.src_ne || r_item[YB+2].flags.det_ne) begin
            n_item_out.corr = pca_pkg::qmul(r_item[YB+2].corr, w_sd_fac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_item[NST-1] <= n_item_out;
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = r_item[NST-1].corr;
    assign o_m_axis_tlast  = r_item[NST-1].last;

    // Checks
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && (r_item[NST-1].flags.year_ne || r_item[NST-1].flags.strat_ne
            || r_item[NST-1].flags.src_ne || r_item[NST-1].flags.det_ne)
        |-> (r_item[NST-1].corr <= pca_pkg::Q_ONE) && (r_item[NST-1].corr >= -pca_pkg::Q_ONE))
        else $error("attenuated correlation outside +/-1.0");

    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[YB] |-> (r_pw[YB] <= pca_pkg::Q_ONE) && (r_pw[YB] >= -pca_pkg::Q_ONE))
        else $error("AR1 power outside +/-1.0");

    a_gap_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_item[0].flags.year_ne |-> r_item[0].gap != '0)
        else $error("year mismatch with zero gap");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] && !r_vld[NST-1] |=> r_vld[NST-1])
        else $error("item failed to enter empty output register");

endmodule

`default_nettype wire
